// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers; every user module has i_clk and i_rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/utf8st_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8st_pkg
// Shared types, constants and lead-byte decode for the UTF-8 sanitizer.
// ----------------------------------------------------------------------------
package utf8st_pkg;

    localparam int WIN_DEPTH = 4;

    typedef logic [7:0] t_byte;
    typedef logic [WIN_DEPTH-1:0][7:0] t_window;

    localparam t_byte C_BUDGET_RESET = 8'd120;
    localparam t_byte C_ASCII_LIMIT  = 8'h80;
    localparam t_byte C_LEAD2_LO     = 8'hC2;
    localparam t_byte C_LEAD2_HI     = 8'hDF;
    localparam t_byte C_LEAD3_LO     = 8'hE0;
    localparam t_byte C_LEAD3_HI     = 8'hEF;
    localparam t_byte C_LEAD4_LO     = 8'hF0;
    localparam t_byte C_LEAD4_HI     = 8'hF4;
    localparam t_byte C_CONT_MASK    = 8'hC0;
    localparam t_byte C_CONT_TAG     = 8'h80;
    localparam t_byte C_REPLACEMENT  = 8'h3F;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COPY,
        S_TERM
    } t_state;

    typedef enum logic [1:0] {
        V_BAD,
        V_COPY,
        V_WAIT
    } t_verdict;

    typedef struct packed {
        t_verdict   verdict;
        logic [2:0] len;
    } t_eval;

    typedef struct packed {
        logic  valid;
        t_byte data;
        logic  present;
        logic  eot;
    } t_emit;

    // sequence length from lead byte, 0 = invalid lead
    function automatic logic [2:0] seq_length(input t_byte lead);
        logic [2:0] len;
        len = 3'd0;
        if (lead < C_ASCII_LIMIT) begin
            len = 3'd1;
        end else if (lead >= C_LEAD2_LO && lead <= C_LEAD2_HI) begin
            len = 3'd2;
        end else if (lead >= C_LEAD3_LO && lead <= C_LEAD3_HI) begin
            len = 3'd3;
        end else if (lead >= C_LEAD4_LO && lead <= C_LEAD4_HI) begin
            len = 3'd4;
        end
        return len;
    endfunction

endpackage

// ----- rtl/utf8st_eval.sv -----
// ----------------------------------------------------------------------------
// utf8st_eval
// Shared check unit: classifies the sequence at the window head.
// ----------------------------------------------------------------------------
module utf8st_eval (
    input  utf8st_pkg::t_window i_win,
    input  logic [2:0]          i_cnt,
    input  utf8st_pkg::t_byte   i_room,
    input  logic                i_fin,
    output utf8st_pkg::t_eval   o_eval
);
    import utf8st_pkg::*;

    logic [2:0] len;
    logic       bad;
    logic       hold;

    always_comb begin
        len  = seq_length(i_win[0]);
        bad  = (len == 3'd0);
        hold = 1'b0;
        for (int k = 1; k < WIN_DEPTH; k++) begin
            if (3'(k) < len && 3'(k) < i_cnt &&
                (i_win[k] & C_CONT_MASK) != C_CONT_TAG) begin
                bad = 1'b1;
            end
        end
        if (!bad && {5'd0, len} > i_room) begin
            bad = 1'b1;
        end
        if (!bad && i_cnt < len) begin
            if (i_fin) begin
                bad = 1'b1;
            end else begin
                hold = 1'b1;
            end
        end
        o_eval.len = len;
        if (bad) begin
            o_eval.verdict = V_BAD;
        end else if (hold) begin
            o_eval.verdict = V_WAIT;
        end else begin
            o_eval.verdict = V_COPY;
        end
    end

endmodule

// ----- rtl/utf8st_seq.sv -----
// ----------------------------------------------------------------------------
// utf8st_seq
// Sequencer: byte window, budget counters, one decision or byte per unstalled cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utf8st_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  utf8st_pkg::t_byte i_text_byte,
    input  logic              i_final_byte,
    input  utf8st_pkg::t_byte i_max_output_bytes,
    input  logic              i_push_ok,
    output utf8st_pkg::t_emit o_emit
);
    import utf8st_pkg::*;

    t_state     r_state, n_state;
    t_window    r_win;
    logic [2:0] r_cnt;
    t_byte      r_emitted;
    logic       r_exh;
    logic       r_fin;
    logic       r_any;
    logic [1:0] r_left;

    t_eval      eval;
    t_byte      room;
    t_byte      emitted_next;
    logic [2:0] cnt_after;
    t_window    win_shift;
    logic       budget_hit;
    logic       loop_end;
    logic       last_out;

    logic       s_take;
    logic       s_pop;
    logic       s_copy_start;
    logic       s_copy_step;
    logic       s_exhaust;
    logic       s_clear;

    assign room         = i_max_output_bytes - r_emitted;
    assign emitted_next = r_emitted + 8'd1;
    assign cnt_after    = r_cnt - 3'd1;
    assign win_shift    = {8'h00, r_win[3], r_win[2], r_win[1]};
    assign budget_hit   = (r_emitted >= i_max_output_bytes);
    assign loop_end     = (r_cnt == 3'd0) || r_exh || budget_hit;
    assign last_out     = r_fin && ((cnt_after == 3'd0) ||
                                    (emitted_next >= i_max_output_bytes));

    utf8st_eval u_eval (
        .i_win  (r_win),
        .i_cnt  (r_cnt),
        .i_room (room),
        .i_fin  (r_fin),
        .o_eval (eval)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (loop_end || eval.verdict == V_WAIT) begin
                    n_state = (r_fin && !r_any) ? S_TERM : S_IDLE;
                end else if (i_push_ok && eval.verdict == V_COPY && eval.len > 3'd1) begin
                    n_state = S_COPY;
                end
            end
            S_COPY: begin
                if (i_push_ok && r_left == 2'd1) begin
                    n_state = S_SCAN;
                end
            end
            S_TERM: begin
                if (i_push_ok) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and strobes
    always_comb begin
        o_in_ready   = 1'b0;
        o_emit       = '0;
        s_take       = 1'b0;
        s_pop        = 1'b0;
        s_copy_start = 1'b0;
        s_copy_step  = 1'b0;
        s_exhaust    = 1'b0;
        s_clear      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                s_take     = i_in_valid;
            end
            S_SCAN: begin
                if (loop_end || eval.verdict == V_WAIT) begin
                    s_exhaust = budget_hit && !(r_fin && r_any);
                    s_clear   = r_fin && r_any;
                end else if (i_push_ok) begin
                    s_pop          = 1'b1;
                    s_copy_start   = (eval.verdict == V_COPY);
                    o_emit.valid   = 1'b1;
                    o_emit.data    = (eval.verdict == V_BAD) ? C_REPLACEMENT : r_win[0];
                    o_emit.present = 1'b1;
                    o_emit.eot     = last_out;
                end
            end
            S_COPY: begin
                if (i_push_ok) begin
                    s_pop          = 1'b1;
                    s_copy_step    = 1'b1;
                    o_emit.valid   = 1'b1;
                    o_emit.data    = r_win[0];
                    o_emit.present = 1'b1;
                    o_emit.eot     = last_out;
                end
            end
            S_TERM: begin
                if (i_push_ok) begin
                    o_emit.valid = 1'b1;
                    o_emit.eot   = 1'b1;
                    s_clear      = 1'b1;
                end
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_win     <= '0;
            r_cnt     <= '0;
            r_emitted <= '0;
            r_exh     <= 1'b0;
            r_fin     <= 1'b0;
            r_any     <= 1'b0;
            r_left    <= '0;
        end else begin
            r_state <= n_state;
            if (s_take) begin
                r_fin <= i_final_byte;
                r_any <= 1'b0;
                if (r_exh || budget_hit) begin
                    r_exh <= 1'b1;
                    r_cnt <= '0;
                    r_win <= '0;
                end else if (r_cnt < 3'(WIN_DEPTH)) begin
                    r_win[r_cnt[1:0]] <= i_text_byte;
                    r_cnt             <= r_cnt + 3'd1;
                end
            end
            if (s_pop) begin
                r_win     <= win_shift;
                r_cnt     <= cnt_after;
                r_emitted <= emitted_next;
                r_any     <= 1'b1;
            end
            if (s_copy_start) begin
                r_left <= 2'(eval.len - 3'd1);
            end
            if (s_copy_step) begin
                r_left <= r_left - 2'd1;
            end
            if (s_exhaust) begin
                r_exh <= 1'b1;
                r_cnt <= '0;
                r_win <= '0;
            end
            if (s_clear) begin
                r_win     <= '0;
                r_cnt     <= '0;
                r_emitted <= '0;
                r_exh     <= 1'b0;
            end
        end
    end

    `ASSERT_IMPL(a_copy_has_bytes, r_state == S_COPY, r_cnt != 3'd0 && r_left != 2'd0)
    `ASSERT_NEXT(a_eot_ends_work, o_emit.valid && o_emit.eot, r_state == S_SCAN || r_state == S_IDLE)
    `ASSERT_NEXT(a_take_scans, s_take, r_state == S_SCAN && r_cnt <= 3'(WIN_DEPTH))

endmodule

// ----- rtl/utf8_sanitize_truncate.sv -----
// ----------------------------------------------------------------------------
// utf8_sanitize_truncate
// Streaming UTF-8 sanitizer with a configurable output byte budget.
// ----------------------------------------------------------------------------
// After a transfer the sequencer scans its byte window; results leave via the output register.
// The sequencer makes one head decision or copies one byte per cycle, the head
//   decisions coming from the check unit.
// A stalled output holds the sequencer; input is taken only when it is idle.
// Reset (sync, active low) clears all text state; budget returns to 120.
// ----------------------------------------------------------------------------
module utf8_sanitize_truncate (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  utf8st_pkg::t_byte i_cfg_wr_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  utf8st_pkg::t_byte i_text_byte,
    input  logic              i_final_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output utf8st_pkg::t_byte o_out_byte,
    output logic              o_byte_present,
    output logic              o_end_of_text
);
    import utf8st_pkg::*;

    t_byte r_max_output_bytes;
    logic  r_out_valid;
    t_byte r_out_byte;
    logic  r_byte_present;
    logic  r_end_of_text;

    t_emit emit;
    logic  push_ok;

    assign push_ok = !r_out_valid || i_out_ready;

    utf8st_seq u_seq (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_text_byte        (i_text_byte),
        .i_final_byte       (i_final_byte),
        .i_max_output_bytes (r_max_output_bytes),
        .i_push_ok          (push_ok),
        .o_emit             (emit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_output_bytes <= C_BUDGET_RESET;
            r_out_valid        <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_output_bytes <= i_cfg_wr_data;
            end
            if (emit.valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.valid) begin
            r_out_byte     <= emit.data;
            r_byte_present <= emit.present;
            r_end_of_text  <= emit.eot;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_byte_present = r_byte_present;
    assign o_end_of_text  = r_end_of_text;

endmodule
